// ----- rtl/core/sse_pkg.sv -----
// Shared types, constants and helpers for the substring search engine.
`default_nettype none

package sse_pkg;

    // Character and register geometry.
    localparam int CHAR_W     = 16;
    localparam int CHAR_BITS  = 16;
    localparam int REG_CHARS  = 16;
    localparam int LEN_W      = 5;
    localparam int OFS_W      = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int IDX_OUT_W  = 16;
    localparam int COUNT_W    = 17;
    localparam int RES_W      = 56;

    // Only the low CHAR_BITS of a text character take part in matching.
    localparam logic [CHAR_W-1:0] CHAR_MASK =
        (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} : CHAR_W'((32'd1 << CHAR_BITS) - 32'd1);

    // ASCII upper-case range and the offset to its lower-case form.
    localparam logic [CHAR_W-1:0] FOLD_LOW  = 16'h0041;
    localparam logic [CHAR_W-1:0] FOLD_HIGH = 16'h005A;
    localparam logic [CHAR_W-1:0] FOLD_ADD  = 16'd32;

    // Register indexes; byte address is 8 times the index.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_0_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_4_7      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_8_11     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_12_15    = 3'd6;

    // Register contents as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]                    pattern_length;
        logic                                case_sensitive;
        logic [OFS_W-1:0]                    start_offset;
        logic [REG_CHARS-1:0][CHAR_W-1:0]    pattern_chars;
    } cfg_t;

    // Per-beat status handed from the cell row to the tally stage.
    typedef struct packed {
        logic take;
        logic hit;
        logic last;
    } beat_t;

    // Fold ASCII upper case to lower case.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= FOLD_LOW && c <= FOLD_HIGH) begin
            r = c + FOLD_ADD;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sse_cfg.sv -----
// APB-style configuration register file for the substring search engine.
`default_nettype none

module sse_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sse_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output sse_pkg::cfg_t                       cfg
);
    import sse_pkg::*;

    logic [LEN_W-1:0]                 len_reg,  len_next;
    logic                             cs_reg,   cs_next;
    logic [OFS_W-1:0]                 ofs_reg,  ofs_next;
    logic [REG_CHARS-1:0][CHAR_W-1:0] pat_reg,  pat_next;
    logic [CFG_IDX_W-1:0]             idx;
    logic                             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign wr_en  = psel & penable & pwrite & pready;

    // Register write decode.
    always_comb begin
        len_next = len_reg;
        cs_next  = cs_reg;
        ofs_next = ofs_reg;
        pat_next = pat_reg;
        if (wr_en) begin
            case (idx)
                REG_PATTERN_LENGTH: len_next = pwdata[LEN_W-1:0];
                REG_CASE_SENSITIVE: cs_next  = pwdata[0];
                REG_START_OFFSET:   ofs_next = pwdata[OFS_W-1:0];
                REG_CHARS_0_3:      pat_next[0 +: 4]  = pwdata;
                REG_CHARS_4_7:      pat_next[4 +: 4]  = pwdata;
                REG_CHARS_8_11:     pat_next[8 +: 4]  = pwdata;
                REG_CHARS_12_15:    pat_next[12 +: 4] = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_W'(1);
            cs_reg  <= 1'b1;
            ofs_reg <= '0;
            pat_reg <= '0;
        end else begin
            len_reg <= len_next;
            cs_reg  <= cs_next;
            ofs_reg <= ofs_next;
            pat_reg <= pat_next;
        end
    end

    // Read back.
    always_comb begin
        case (idx)
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(len_reg);
            REG_CASE_SENSITIVE: prdata = CFG_DATA_W'(cs_reg);
            REG_START_OFFSET:   prdata = CFG_DATA_W'(ofs_reg);
            REG_CHARS_0_3:      prdata = pat_reg[0 +: 4];
            REG_CHARS_4_7:      prdata = pat_reg[4 +: 4];
            REG_CHARS_8_11:     prdata = pat_reg[8 +: 4];
            REG_CHARS_12_15:    prdata = pat_reg[12 +: 4];
            default:            prdata = '0;
        endcase
    end

    assign cfg.pattern_length = len_reg;
    assign cfg.case_sensitive = cs_reg;
    assign cfg.start_offset   = ofs_reg;
    assign cfg.pattern_chars  = pat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sse_cell.sv -----
// One compare cell of the shift-and row: holds one prefix-progress bit.
`default_nettype none

module sse_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       adv,
    input  wire logic                       clr,
    input  wire logic                       take,
    input  wire logic                       carry_in,
    input  wire logic [sse_pkg::CHAR_W-1:0] ch,
    input  wire logic [sse_pkg::CHAR_W-1:0] ch_fold,
    input  wire logic [sse_pkg::CHAR_W-1:0] pat,
    input  wire logic                       case_sensitive,
    output logic                            hit,
    output logic                            progress
);
    import sse_pkg::*;

    logic eq;
    logic progress_reg, progress_next;

    // Character compare, exact or with ASCII case folded.
    assign eq  = case_sensitive ? (ch == pat) : (ch_fold == fold_char(pat));
    assign hit = carry_in & eq;

    // The prefix grows when the previous cell had its prefix and this char matches.
    always_comb begin
        progress_next = progress_reg;
        if (adv) begin
            if (clr) begin
                progress_next = 1'b0;
            end else if (take) begin
                progress_next = hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= 1'b0;
        end else begin
            progress_reg <= progress_next;
        end
    end

    assign progress = progress_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sse_tally.sv -----
// Match bookkeeping and result output register of the substring search engine.
`default_nettype none

module sse_tally #(
    parameter int POS_W = 17
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       fire,
    input  wire sse_pkg::beat_t             beat,
    input  wire logic [POS_W-1:0]           pos,
    input  wire logic [sse_pkg::LEN_W-1:0]  len,
    input  wire logic [sse_pkg::OFS_W-1:0]  start_offset,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic [sse_pkg::RES_W-1:0]       m_tdata
);
    import sse_pkg::*;

    localparam int WIDE_W = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    logic                 first_seen_reg,  first_seen_upd,  first_seen_next;
    logic [IDX_OUT_W-1:0] first_start_reg, first_start_upd, first_start_next;
    logic                 last_seen_reg,   last_seen_upd,   last_seen_next;
    logic [IDX_OUT_W-1:0] last_start_reg,  last_start_upd,  last_start_next;
    logic [POS_W-1:0]     total_reg,       total_upd,       total_next;
    logic [POS_W-1:0]     nas_reg,         nas_upd,         nas_next;
    logic                 ovf_reg,         ovf_upd,         ovf_next;
    logic                 m_valid_reg,     m_valid_next;
    logic [RES_W-1:0]     m_data_reg;
    logic [WIDE_W-1:0]    start_w;
    logic [WIDE_W-1:0]    total_w;
    logic                 done;

    assign done    = fire & beat.last;
    assign start_w = WIDE_W'(pos) + WIDE_W'(1) - WIDE_W'(len);

    // Fold one completed match into the running results.
    always_comb begin
        first_seen_upd  = first_seen_reg;
        first_start_upd = first_start_reg;
        last_seen_upd   = last_seen_reg;
        last_start_upd  = last_start_reg;
        total_upd       = total_reg;
        nas_upd         = nas_reg;
        ovf_upd         = ovf_reg;
        if (fire) begin
            ovf_upd = ovf_reg | ~beat.take;
            if (beat.hit) begin
                if (!first_seen_reg && start_w >= WIDE_W'(start_offset)) begin
                    first_seen_upd  = 1'b1;
                    first_start_upd = start_w[IDX_OUT_W-1:0];
                end
                last_seen_upd  = 1'b1;
                last_start_upd = start_w[IDX_OUT_W-1:0];
                if (start_w >= WIDE_W'(nas_reg)) begin
                    total_upd = total_reg + POS_W'(1);
                    nas_upd   = POS_W'(start_w + WIDE_W'(len));
                end
            end
        end
    end

    // The text state clears once its last beat has been reported.
    always_comb begin
        if (done) begin
            first_seen_next  = 1'b0;
            first_start_next = '0;
            last_seen_next   = 1'b0;
            last_start_next  = '0;
            total_next       = '0;
            nas_next         = '0;
            ovf_next         = 1'b0;
        end else begin
            first_seen_next  = first_seen_upd;
            first_start_next = first_start_upd;
            last_seen_next   = last_seen_upd;
            last_start_next  = last_start_upd;
            total_next       = total_upd;
            nas_next         = nas_upd;
            ovf_next         = ovf_upd;
        end
    end

    assign total_w = WIDE_W'(total_upd);

    // Output beat handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_seen_reg  <= 1'b0;
            first_start_reg <= '0;
            last_seen_reg   <= 1'b0;
            last_start_reg  <= '0;
            total_reg       <= '0;
            nas_reg         <= '0;
            ovf_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            first_seen_reg  <= first_seen_next;
            first_start_reg <= first_start_next;
            last_seen_reg   <= last_seen_next;
            last_start_reg  <= last_start_next;
            total_reg       <= total_next;
            nas_reg         <= nas_next;
            ovf_reg         <= ovf_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Result payload, highest field first.
    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= {4'b0000, ovf_upd, total_w[COUNT_W-1:0], last_start_upd,
                           last_seen_upd, first_start_upd, first_seen_upd};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A finished text always produces a result beat.
    assert property (@(posedge aclk) disable iff (!aresetn) done |=> m_valid_reg)
        else $error("result beat missing after last text beat");

    // A nonzero match count implies that at least one match has been seen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg != '0) |-> last_seen_reg)
        else $error("match count without any match");

    // State is clear after a text completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (total_reg == '0 && !ovf_reg && !last_seen_reg))
        else $error("text state not cleared");

endmodule

`default_nettype wire

// ----- rtl/core/substring_search_engine.sv -----
// Top level of the substring search engine: row of compare cells, tally, registers.
// Throughput: one text beat per cycle; s_tready drops only while a last beat waits
//   for the result register to be taken.
// Result path: the accepting edge loads the cell row and stage one with the last beat; the
//   tally then loads the result register and raises m_tvalid once stage one is not stalled.
// Reset: synchronous, active low; clears the cell row, counters and tally, and loads
//   pattern_length 1, case_sensitive 1 and zero in the other registers.
`default_nettype none

module substring_search_engine #(
    parameter int PATTERN_MAX = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: text_char[15:0]
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,
    input  wire logic                           s_tlast,
    // m_tdata: first_found[0], first_index[16:1], last_found[17], last_index[33:18],
    //          match_count[50:34], overflow[51], zero[55:52]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sse_pkg::RES_W-1:0]           m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sse_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import sse_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT + 1);

    cfg_t                    cfg;
    logic                    accept;
    logic                    stall;
    logic                    take;
    logic                    hit_any;
    logic [CHAR_W-1:0]       ch;
    logic [CHAR_W-1:0]       ch_fold;
    logic [PATTERN_MAX-1:0]  hit_vec;
    logic [PATTERN_MAX-1:0]  progress_vec;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    s1_valid_reg, s1_valid_next;
    beat_t                   s1_reg, s1_next;
    logic [POS_W-1:0]        s1_pos_reg, s1_pos_next;

    sse_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A last beat in stage one holds while the result register is still full.
    assign stall    = s1_valid_reg & s1_reg.last & m_tvalid & ~m_tready;
    assign s_tready = ~stall;
    assign accept   = s_tvalid & s_tready;

    // Characters past the text limit are not matched.
    assign take    = (pos_reg < POS_W'(MAX_TEXT));
    assign ch      = s_tdata & CHAR_MASK;
    assign ch_fold = fold_char(ch);

    // Row of compare cells; each passes its prefix bit to the next.
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [CHAR_W-1:0] pat;
        logic              carry;
        if (j < REG_CHARS) begin : g_pat
            assign pat = cfg.pattern_chars[j];
        end else begin : g_zero
            assign pat = '0;
        end
        if (j == 0) begin : g_head
            assign carry = 1'b1;
        end else begin : g_link
            assign carry = progress_vec[j-1];
        end
        sse_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .adv            (accept),
            .clr            (s_tlast),
            .take           (take),
            .carry_in       (carry),
            .ch             (ch),
            .ch_fold        (ch_fold),
            .pat            (pat),
            .case_sensitive (cfg.case_sensitive),
            .hit            (hit_vec[j]),
            .progress       (progress_vec[j])
        );
    end

    // Full match when the cell at the pattern length completes its prefix.
    always_comb begin
        hit_any = 1'b0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (int'(cfg.pattern_length) == j + 1) begin
                hit_any = hit_any | hit_vec[j];
            end
        end
        hit_any = hit_any & take;
    end

    // Text position and stage-one register.
    always_comb begin
        pos_next      = pos_reg;
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        s1_pos_next   = s1_pos_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (take) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (!stall) begin
            s1_valid_next = accept;
            if (accept) begin
                s1_next.take = take;
                s1_next.hit  = hit_any;
                s1_next.last = s_tlast;
                s1_pos_next  = pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg     <= s1_next;
        s1_pos_reg <= s1_pos_next;
    end

    sse_tally #(
        .POS_W (POS_W)
    ) u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (s1_valid_reg & ~stall),
        .beat         (s1_reg),
        .pos          (s1_pos_reg),
        .len          (cfg.pattern_length),
        .start_offset (cfg.start_offset),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

    // A blocked last beat stays in stage one.
    assert property (@(posedge aclk) disable iff (!aresetn) stall |=> s1_valid_reg)
        else $error("stalled last beat dropped");

    // The position counter restarts after a last beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (pos_reg == '0))
        else $error("text position not restarted");

    // The cell row is empty at the start of every text.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (progress_vec == '0))
        else $error("cell row not cleared");

    // Only characters inside the text limit can complete a match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.hit) |-> s1_reg.take)
        else $error("match on an ignored character");

endmodule

`default_nettype wire
